>>> src/mhpq_pkg.sv
package mhpq_pkg;

   localparam int CAPACITY  = 1024;
   localparam int ITEM_BITS = 10;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int PRIO_W   = 32;

   localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP      = 2'd1;
   localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TRACKING = 1'b0;

endpackage

>>> src/mhpq_if.sv
interface mhpq_req_if #(
   parameter int ITEM_BITS = mhpq_pkg::ITEM_BITS
);
   logic                              valid;
   logic                              ready;
   logic [mhpq_pkg::OP_W-1:0]         opcode;
   logic [ITEM_BITS-1:0]              item_id;
   logic signed [mhpq_pkg::PRIO_W-1:0] priority_req;

   modport source (output valid, opcode, item_id, priority_req, input ready);
   modport sink (input valid, opcode, item_id, priority_req, output ready);
endinterface

interface mhpq_rsp_if #(
   parameter int ITEM_BITS = mhpq_pkg::ITEM_BITS,
   parameter int CNT_W     = $clog2(mhpq_pkg::CAPACITY + 1)
);
   logic                               valid;
   logic                               ready;
   logic [mhpq_pkg::STATUS_W-1:0]      status;
   logic [ITEM_BITS-1:0]               popped_id;
   logic signed [mhpq_pkg::PRIO_W-1:0] popped_priority;
   logic [CNT_W-1:0]                   entry_count_out;

   modport source (output valid, status, popped_id, popped_priority, entry_count_out,
                   input ready);
   modport sink (input valid, status, popped_id, popped_priority, entry_count_out,
                 output ready);
endinterface

>>> src/min_heap_priority_queue.sv
// Insert and decrease-key climb the heap one level per read-compare-write round (ST_UP_RD,
// ST_UP_CMP); pop descends one level per round (ST_DN_L, ST_DN_R, ST_DN_DEC), as the heap
// memory has a single read port.
// A finished beat waits in the output register while the next item is taken.
// Reset (synchronous, active high) clears count and tracking, then a clearing pass over all
// 2**ITEM_BITS item ids zeroes the present bits; no item is accepted during it.
module min_heap_priority_queue #(
   parameter int CAPACITY  = mhpq_pkg::CAPACITY,
   parameter int ITEM_BITS = mhpq_pkg::ITEM_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   mhpq_req_if.sink                        req_bus,
   mhpq_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mhpq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mhpq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mhpq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = ADDR_W + 2;
   localparam int ID_COUNT = 1 << ITEM_BITS;
   localparam int PRIO_W   = mhpq_pkg::PRIO_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHECK  = 4'd1;
   localparam logic [3:0] ST_POP_P  = 4'd2;
   localparam logic [3:0] ST_POP_L  = 4'd3;
   localparam logic [3:0] ST_DK     = 4'd4;
   localparam logic [3:0] ST_UP_RD  = 4'd5;
   localparam logic [3:0] ST_UP_CMP = 4'd6;
   localparam logic [3:0] ST_DN_L   = 4'd7;
   localparam logic [3:0] ST_DN_R   = 4'd8;
   localparam logic [3:0] ST_DN_DEC = 4'd9;
   localparam logic [3:0] ST_FIN    = 4'd10;

   logic [3:0]                    state_ff, state_in;
   logic [mhpq_pkg::OP_W-1:0]     op_ff, op_in;
   logic [ITEM_BITS-1:0]          id_ff, id_in;
   logic signed [PRIO_W-1:0]      pr_ff, pr_in;
   logic [ITEM_BITS-1:0]          cur_id_ff, cur_id_in;
   logic signed [PRIO_W-1:0]      cur_pr_ff, cur_pr_in;
   logic [ITEM_BITS-1:0]          lt_id_ff, lt_id_in;
   logic signed [PRIO_W-1:0]      lt_pr_ff, lt_pr_in;
   logic [ADDR_W-1:0]             p_ff, p_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [mhpq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ITEM_BITS-1:0]          pid_ff, pid_in;
   logic signed [PRIO_W-1:0]      ppr_ff, ppr_in;
   logic                          have_r_ff, have_r_in;
   logic                          skip_ff, skip_in;
   logic                          clr_ff, clr_in;
   logic [ITEM_BITS-1:0]          clr_idx_ff, clr_idx_in;
   logic                          tracking_ff, tracking_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mhpq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ITEM_BITS-1:0]          rsp_id_ff, rsp_id_in;
   logic signed [PRIO_W-1:0]      rsp_pr_ff, rsp_pr_in;
   logic [CNT_W-1:0]              rsp_count_ff, rsp_count_in;

   logic [ITEM_BITS-1:0]     heap_id_mem [CAPACITY];
   logic signed [PRIO_W-1:0] heap_pr_mem [CAPACITY];
   logic [ADDR_W-1:0]        pos_mem [ID_COUNT];
   logic                     pres_mem [ID_COUNT];

   logic [ITEM_BITS-1:0]     hq_id_ff;
   logic signed [PRIO_W-1:0] hq_pr_ff;
   logic [ADDR_W-1:0]        pq_pos_ff;
   logic                     pq_pres_ff;

   logic                     hw_en, hr_en;
   logic [ADDR_W-1:0]        hw_addr, hr_addr;
   logic [ITEM_BITS-1:0]     hw_id;
   logic signed [PRIO_W-1:0] hw_pr;
   logic                     pw_pos_en, pw_pres_en, pw_pres, pr_en;
   logic [ITEM_BITS-1:0]     pw_addr, pr_addr;
   logic [ADDR_W-1:0]        pw_pos;

   logic              req_accept, csr_write;
   logic [ADDR_W-1:0] parent;
   logic [IDX_W-1:0]  left_idx, right_idx;
   logic              left_less, pick_r;
   logic signed [PRIO_W-1:0] best_pr;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && !clr_ff;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[mhpq_pkg::CSR_ADDR_W-1:2] == mhpq_pkg::CSR_IDX_TRACKING) ?
                       {{(mhpq_pkg::CSR_DATA_W-1){1'b0}}, tracking_ff} : '0;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.popped_id       = rsp_id_ff;
   assign rsp_bus.popped_priority = rsp_pr_ff;
   assign rsp_bus.entry_count_out = rsp_count_ff;

   assign parent    = (p_ff - ADDR_W'(1)) >> 1;
   assign left_idx  = (IDX_W'(p_ff) << 1) + IDX_W'(1);
   assign right_idx = left_idx + IDX_W'(1);
   assign left_less = lt_pr_ff < cur_pr_ff;
   assign best_pr   = left_less ? lt_pr_ff : cur_pr_ff;
   assign pick_r    = have_r_ff && (hq_pr_ff < best_pr);

   always_ff @(posedge clock) begin
      if (hw_en) begin
         heap_id_mem[hw_addr] <= hw_id;
         heap_pr_mem[hw_addr] <= hw_pr;
      end
      if (hr_en) begin
         hq_id_ff <= heap_id_mem[hr_addr];
         hq_pr_ff <= heap_pr_mem[hr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pw_pos_en) pos_mem[pw_addr] <= pw_pos;
      if (pw_pres_en) pres_mem[pw_addr] <= pw_pres;
      if (pr_en) begin
         pq_pos_ff  <= pos_mem[pr_addr];
         pq_pres_ff <= pres_mem[pr_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      id_in = id_ff;
      pr_in = pr_ff;
      cur_id_in = cur_id_ff;
      cur_pr_in = cur_pr_ff;
      lt_id_in = lt_id_ff;
      lt_pr_in = lt_pr_ff;
      p_in = p_ff;
      count_in = count_ff;
      status_in = status_ff;
      pid_in = pid_ff;
      ppr_in = ppr_ff;
      have_r_in = have_r_ff;
      skip_in = skip_ff;
      clr_in = clr_ff;
      clr_idx_in = clr_idx_ff;
      tracking_in = tracking_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in = rsp_id_ff;
      rsp_pr_in = rsp_pr_ff;
      rsp_count_in = rsp_count_ff;
      hw_en = 1'b0;
      hw_addr = p_ff;
      hw_id = cur_id_ff;
      hw_pr = cur_pr_ff;
      hr_en = 1'b0;
      hr_addr = '0;
      pw_pos_en = 1'b0;
      pw_pres_en = 1'b0;
      pw_addr = cur_id_ff;
      pw_pos = p_ff;
      pw_pres = 1'b1;
      pr_en = 1'b0;
      pr_addr = req_bus.item_id;

      if (csr_write && csr_paddr[mhpq_pkg::CSR_ADDR_W-1:2] == mhpq_pkg::CSR_IDX_TRACKING) begin
         tracking_in = csr_pwdata[0];
      end

      if (clr_ff) begin
         pw_pres_en = 1'b1;
         pw_addr = clr_idx_ff;
         pw_pres = 1'b0;
         clr_idx_in = clr_idx_ff + ITEM_BITS'(1);
         if (clr_idx_ff == '1) clr_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in = req_bus.opcode;
               id_in = req_bus.item_id;
               pr_in = req_bus.priority_req;
               status_in = mhpq_pkg::STATUS_DONE;
               pid_in = '0;
               ppr_in = '0;
               pr_en = 1'b1;
               hr_en = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_FIN;
            case (op_ff)
               mhpq_pkg::OP_INSERT: begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = mhpq_pkg::STATUS_FULL;
                  end else if (tracking_ff && pq_pres_ff) begin
                     status_in = mhpq_pkg::STATUS_REFUSED;
                  end else begin
                     cur_id_in = id_ff;
                     cur_pr_in = pr_ff;
                     p_in = count_ff[ADDR_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_UP_RD;
                  end
               end
               mhpq_pkg::OP_POP: begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::STATUS_EMPTY;
                  end else begin
                     pid_in = hq_id_ff;
                     ppr_in = hq_pr_ff;
                     count_in = count_ff - CNT_W'(1);
                     pr_en = 1'b1;
                     pr_addr = hq_id_ff;
                     state_in = ST_POP_P;
                  end
               end
               mhpq_pkg::OP_DECREASE: begin
                  if (!tracking_ff || !pq_pres_ff || IDX_W'(pq_pos_ff) >= IDX_W'(count_ff)) begin
                     status_in = mhpq_pkg::STATUS_REFUSED;
                  end else begin
                     p_in = pq_pos_ff;
                     hr_en = 1'b1;
                     hr_addr = pq_pos_ff;
                     state_in = ST_DK;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_POP_P: begin
            if (pq_pos_ff == '0) begin
               pw_pres_en = 1'b1;
               pw_addr = pid_ff;
               pw_pres = 1'b0;
            end
            if (count_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               hr_en = 1'b1;
               hr_addr = count_ff[ADDR_W-1:0];
               state_in = ST_POP_L;
            end
         end
         ST_POP_L: begin
            cur_id_in = hq_id_ff;
            cur_pr_in = hq_pr_ff;
            p_in = '0;
            skip_in = 1'b0;
            state_in = ST_DN_L;
         end
         ST_DK: begin
            if (hq_id_ff != id_ff || pr_ff > hq_pr_ff) begin
               status_in = mhpq_pkg::STATUS_REFUSED;
               state_in = ST_FIN;
            end else begin
               cur_id_in = id_ff;
               cur_pr_in = pr_ff;
               state_in = ST_UP_RD;
            end
         end
         ST_UP_RD: begin
            if (p_ff == '0) begin
               hw_en = 1'b1;
               pw_pos_en = 1'b1;
               pw_pres_en = (op_ff == mhpq_pkg::OP_INSERT);
               state_in = ST_FIN;
            end else begin
               hr_en = 1'b1;
               hr_addr = parent;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            hw_en = 1'b1;
            pw_pos_en = 1'b1;
            if (cur_pr_ff < hq_pr_ff) begin
               hw_id = hq_id_ff;
               hw_pr = hq_pr_ff;
               pw_addr = hq_id_ff;
               p_in = parent;
               state_in = ST_UP_RD;
            end else begin
               pw_pres_en = (op_ff == mhpq_pkg::OP_INSERT);
               state_in = ST_FIN;
            end
         end
         ST_DN_L: begin
            if (left_idx < IDX_W'(count_ff)) begin
               hr_en = 1'b1;
               hr_addr = left_idx[ADDR_W-1:0];
               state_in = ST_DN_R;
            end else begin
               hw_en = 1'b1;
               pw_pos_en = !skip_ff;
               state_in = ST_FIN;
            end
         end
         ST_DN_R: begin
            lt_id_in = hq_id_ff;
            lt_pr_in = hq_pr_ff;
            have_r_in = right_idx < IDX_W'(count_ff);
            if (right_idx < IDX_W'(count_ff)) begin
               hr_en = 1'b1;
               hr_addr = right_idx[ADDR_W-1:0];
            end
            state_in = ST_DN_DEC;
         end
         ST_DN_DEC: begin
            hw_en = 1'b1;
            if (pick_r || left_less) begin
               hw_id = pick_r ? hq_id_ff : lt_id_ff;
               hw_pr = pick_r ? hq_pr_ff : lt_pr_ff;
               pw_pos_en = 1'b1;
               pw_addr = hw_id;
               skip_in = (hw_id == cur_id_ff);
               p_in = pick_r ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
               state_in = ST_DN_L;
            end else begin
               pw_pos_en = !skip_ff;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in = pid_ff;
               rsp_pr_in = ppr_ff;
               rsp_count_in = count_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
         tracking_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff <= clr_in;
         clr_idx_ff <= clr_idx_in;
         tracking_ff <= tracking_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      id_ff <= id_in;
      pr_ff <= pr_in;
      cur_id_ff <= cur_id_in;
      cur_pr_ff <= cur_pr_in;
      lt_id_ff <= lt_id_in;
      lt_pr_ff <= lt_pr_in;
      p_ff <= p_in;
      status_ff <= status_in;
      pid_ff <= pid_in;
      ppr_ff <= ppr_in;
      have_r_ff <= have_r_in;
      skip_ff <= skip_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff <= rsp_id_in;
      rsp_pr_ff <= rsp_pr_in;
      rsp_count_ff <= rsp_count_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_bus.ready)
      else $error("item taken during clearing pass");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_CHECK)
      else $error("accepted beat not processed");

   a_fail_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != mhpq_pkg::STATUS_DONE |->
         rsp_id_ff == '0 && rsp_pr_ff == '0)
      else $error("failed operation reports a popped entry");
`endif

endmodule

>>> test/min_heap_priority_queue_test.sv
`timescale 1ns / 100ps

module min_heap_priority_queue_test;

   localparam int OP_W       = mhpq_pkg::OP_W;
   localparam int STATUS_W   = mhpq_pkg::STATUS_W;
   localparam int PRIO_W     = mhpq_pkg::PRIO_W;
   localparam int ITEM_BITS  = mhpq_pkg::ITEM_BITS;
   localparam int CAPACITY   = mhpq_pkg::CAPACITY;
   localparam int CSR_ADDR_W = mhpq_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = mhpq_pkg::CSR_DATA_W;

   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TRACKING = {mhpq_pkg::CSR_IDX_TRACKING, 2'b00};
   localparam int ID_COUNT = 1 << ITEM_BITS;
   localparam int SETTLE = 40;

   typedef struct {
      logic [OP_W-1:0]          opcode;
      logic [ITEM_BITS-1:0]     id;
      logic signed [PRIO_W-1:0] prio;
   } heap_op_type;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic [ITEM_BITS-1:0]     id;
      logic signed [PRIO_W-1:0] prio;
      logic [10:0]              count;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   mhpq_req_if req ();
   mhpq_rsp_if rsp ();

   min_heap_priority_queue u_dut (
      .clock(clock), .reset(reset), .req_bus(req), .rsp_bus(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow heap
   logic [ITEM_BITS-1:0]     hp_ids[CAPACITY];
   logic signed [PRIO_W-1:0] hp_prio[CAPACITY];
   int                       hp_pos[ID_COUNT];
   bit                       hp_present[ID_COUNT];
   int                       hp_count = 0;
   bit                       hp_track = 1'b0;

   heap_op_type  pending_ops[$];
   heap_rsp_type expected_rsps[$];
   int        seen_ids[$];
   bit        seen_flag[ID_COUNT];
   bit        mark_seen = 1'b1;
   bit        quiet = 1'b0;
   bit        hold_req = 1'b0;
   int        hold_count = 0;
   int        errors = 0;
   int        status_hits[4];
   int        beats_out = 0;

   function automatic void heap_place(int p, logic [ITEM_BITS-1:0] id,
                                      logic signed [PRIO_W-1:0] pr);
      hp_ids[p] = id;
      hp_prio[p] = pr;
      hp_pos[id] = p;
   endfunction

   function automatic void heap_swap(int a, int b);
      logic [ITEM_BITS-1:0] id;
      logic signed [PRIO_W-1:0] pr;
      id = hp_ids[a];
      pr = hp_prio[a];
      heap_place(a, hp_ids[b], hp_prio[b]);
      heap_place(b, id, pr);
   endfunction

   function automatic void heap_sift_up(int p);
      int up;
      while (p != 0) begin
         up = (p - 1) / 2;
         if (!(hp_prio[p] < hp_prio[up])) break;
         heap_swap(p, up);
         p = up;
      end
   endfunction

   function automatic void heap_sift_down(int p);
      int best;
      forever begin
         best = p;
         if (2*p+1 < hp_count && hp_prio[2*p+1] < hp_prio[best]) best = 2*p+1;
         if (2*p+2 < hp_count && hp_prio[2*p+2] < hp_prio[best]) best = 2*p+2;
         if (best == p) break;
         heap_swap(best, p);
         p = best;
      end
   endfunction

   function automatic heap_rsp_type heap_apply(heap_op_type op);
      heap_rsp_type r;
      int p;
      r.status = mhpq_pkg::STATUS_DONE;
      r.id = '0;
      r.prio = '0;
      case (op.opcode)
         mhpq_pkg::OP_INSERT: begin
            if (hp_count >= CAPACITY) r.status = mhpq_pkg::STATUS_FULL;
            else if (hp_track && hp_present[op.id]) r.status = mhpq_pkg::STATUS_REFUSED;
            else begin
               heap_place(hp_count, op.id, op.prio);
               hp_present[op.id] = 1'b1;
               hp_count++;
               heap_sift_up(hp_count - 1);
            end
         end
         mhpq_pkg::OP_POP: begin
            if (hp_count == 0) r.status = mhpq_pkg::STATUS_EMPTY;
            else begin
               r.id = hp_ids[0];
               r.prio = hp_prio[0];
               if (hp_pos[r.id] == 0) hp_present[r.id] = 1'b0;
               hp_count--;
               if (hp_count != 0) begin
                  heap_place(0, hp_ids[hp_count], hp_prio[hp_count]);
                  heap_sift_down(0);
               end
            end
         end
         mhpq_pkg::OP_DECREASE: begin
            p = hp_pos[op.id];
            if (!hp_track || !hp_present[op.id] || p >= hp_count || hp_ids[p] != op.id)
               r.status = mhpq_pkg::STATUS_REFUSED;
            else if (op.prio > hp_prio[p]) r.status = mhpq_pkg::STATUS_REFUSED;
            else begin
               hp_prio[p] = op.prio;
               heap_sift_up(p);
            end
         end
         default: ;
      endcase
      r.count = 11'(hp_count);
      return r;
   endfunction

   // driver
   heap_op_type drv_op;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!(req.valid && !req.ready)) begin
         if (req.valid && req.ready) begin
            drv_op = pending_ops.pop_front();
            expected_rsps.push_back(heap_apply(drv_op));
         end
         if (pending_ops.size() > 0 && (quiet || $urandom_range(99) >= 34)) begin
            req.valid <= 1'b1;
            req.opcode <= pending_ops[0].opcode;
            req.item_id <= pending_ops[0].id;
            req.priority_req <= pending_ops[0].prio;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   heap_rsp_type mon_exp;
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         beats_out++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            mon_exp = expected_rsps.pop_front();
            status_hits[mon_exp.status]++;
            if (rsp.status !== mon_exp.status) begin
               $error("status: expected %0d actual %0d", mon_exp.status, rsp.status);
               errors++;
            end
            if (rsp.popped_id !== mon_exp.id) begin
               $error("popped_id: expected %0d actual %0d", mon_exp.id, rsp.popped_id);
               errors++;
            end
            if (rsp.popped_priority !== mon_exp.prio) begin
               $error("popped_priority: expected %0d actual %0d", mon_exp.prio,
                      rsp.popped_priority);
               errors++;
            end
            if (rsp.entry_count_out !== mon_exp.count) begin
               $error("entry_count_out: expected %0d actual %0d", mon_exp.count,
                      rsp.entry_count_out);
               errors++;
            end
         end
      end
      if (hold_req) begin
         hold_req = 1'b0;
         hold_count = 400;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= quiet || $urandom_range(99) >= 34;
      end
   end

   task automatic push_op(logic [OP_W-1:0] op, int id, int pr);
      heap_op_type o;
      o.opcode = op;
      o.id = ITEM_BITS'(id);
      o.prio = pr;
      if (op == mhpq_pkg::OP_INSERT && mark_seen && !seen_flag[o.id]) begin
         seen_flag[o.id] = 1'b1;
         seen_ids.push_back(o.id);
      end
      pending_ops.push_back(o);
   endtask

   task automatic push_random(int n);
      int r, id, pr;
      logic [OP_W-1:0] op;
      repeat (n) begin
         r = $urandom_range(99);
         op = r < 45 ? mhpq_pkg::OP_INSERT : r < 75 ? mhpq_pkg::OP_POP :
              r < 95 ? mhpq_pkg::OP_DECREASE : OP_NONE;
         id = $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(ID_COUNT - 1);
         if (op == mhpq_pkg::OP_DECREASE) begin
            if (seen_ids.size() == 0) op = mhpq_pkg::OP_INSERT;
            else id = seen_ids[$urandom_range(seen_ids.size() - 1)];
         end
         case ($urandom_range(7))
            0: pr = 32'h7fffffff;
            1: pr = 32'h80000000;
            2: pr = int'($urandom_range(15)) - 8;
            default: pr = $urandom;
         endcase
         push_op(op, id, pr);
      end
   endtask

   task automatic drain;
      while (pending_ops.size() > 0 || expected_rsps.size() > 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_TRACKING;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      hp_track = value[0];
      @(negedge clock);
   endtask

   task automatic csr_check;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_TRACKING;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[0] !== hp_track) begin
         $error("index_tracking: expected %0d actual %0d", hp_track, csr_prdata[0]);
         errors++;
      end
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      req.valid = 1'b0;
      req.opcode = OP_NONE;
      req.item_id = '0;
      req.priority_req = '0;
      rsp.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_check;
      csr_write(0);
      push_op(mhpq_pkg::OP_POP, 0, 0);
      push_op(mhpq_pkg::OP_INSERT, 0, 32'h7fffffff);
      push_op(mhpq_pkg::OP_INSERT, ID_COUNT - 1, 32'h80000000);
      push_op(mhpq_pkg::OP_INSERT, 0, 0);
      push_op(mhpq_pkg::OP_DECREASE, 0, 32'h80000000);
      push_op(OP_NONE, ID_COUNT - 1, 32'h7fffffff);
      repeat (4) push_op(mhpq_pkg::OP_POP, 0, 0);
      drain;
      csr_write(1);
      csr_check;
      push_op(mhpq_pkg::OP_INSERT, 5, 100);
      push_op(mhpq_pkg::OP_INSERT, 5, 3);
      push_op(mhpq_pkg::OP_INSERT, 7, -5);
      push_op(mhpq_pkg::OP_DECREASE, 5, 200);
      push_op(mhpq_pkg::OP_DECREASE, 5, 100);
      push_op(mhpq_pkg::OP_DECREASE, 5, 32'h80000000);
      push_op(mhpq_pkg::OP_DECREASE, ID_COUNT - 1, -9);
      repeat (3) push_op(mhpq_pkg::OP_POP, 0, 0);
      drain;
      push_random(80);
      hold_req = 1'b1;
      push_random(80);
      drain;
      csr_write(0);
      csr_check;
      quiet = 1'b1;
      push_random(40);
      drain;
      quiet = 1'b0;
      push_random(40);
      drain;
      mark_seen = 1'b0;
      repeat (CAPACITY + 6) push_op(mhpq_pkg::OP_INSERT, $urandom_range(ID_COUNT - 1),
                                    $urandom);
      repeat (40) push_op(mhpq_pkg::OP_POP, $urandom_range(ID_COUNT - 1), $urandom);
      drain;
      mark_seen = 1'b1;
      csr_write(1);
      csr_check;
      push_random(40);
      drain;
      $display("beats %0d: done %0d refused %0d empty %0d full %0d", beats_out,
               status_hits[mhpq_pkg::STATUS_DONE], status_hits[mhpq_pkg::STATUS_REFUSED],
               status_hits[mhpq_pkg::STATUS_EMPTY], status_hits[mhpq_pkg::STATUS_FULL]);
      $display("covered tracking on/off, duplicates, decrease-key, fill to full");
      if (errors == 0) $display("min_heap_priority_queue regression: pass");
      else $display("min_heap_priority_queue regression: fail");
      $finish;
   end

   initial begin
      #40ms;
      $display("min_heap_priority_queue regression: fail");
      $finish;
   end

endmodule
